@@ hw/rtl/cdm_pkg.sv @@
// Shared types and constants for the correlation distance matrix block.
// Used by cdm_cell, cdm_dist and correlation_distance_matrix; no dependencies.

package cdm_pkg;

    localparam int MAX_GENES   = 16;
    localparam int MAX_SAMPLES = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int GENE_W      = 4;    // gene index width
    localparam int GCNT_W      = 5;    // gene_count register width
    localparam int CNT_W       = 9;    // complete row count, holds MAX_SAMPLES
    localparam int SUM_W       = 24;   // column sum
    localparam int PROD_W      = 40;   // cross-product sum
    localparam int VAR_W       = 50;   // n*P - Si*Sj, signed
    localparam int SQ_W        = 100;  // product of two variance terms
    localparam int RES_W       = 134;  // search residual and trial terms
    localparam int DIST_W      = 16;
    localparam int Q_BITS      = 16;   // correlation bits found by the search
    localparam int Q_FRAC      = 15;   // fraction bits of the correlation

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam logic [DIST_W-1:0] DIST_ONE  = DIST_W'(32768);
    localparam logic [DIST_W-1:0] DIST_ZERO = '0;

    typedef struct packed {
        logic [1:0]                    kind;
        logic signed [SAMPLE_BITS-1:0] sample_value;
        logic [GENE_W-1:0]             gene_a;
        logic [GENE_W-1:0]             gene_b;
    } item_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              status;
        logic              capacity_exceeded;
    } result_t;

    // Sample traveling down the cell chain
    typedef struct packed {
        logic                          valid;
        logic signed [SAMPLE_BITS-1:0] value;
        logic [GENE_W-1:0]             col;
    } token_t;

    // Operands gathered for one distance query
    typedef struct packed {
        logic [CNT_W-1:0]         n;
        logic signed [PROD_W-1:0] paa;
        logic signed [PROD_W-1:0] pbb;
        logic signed [PROD_W-1:0] pab;
        logic signed [SUM_W-1:0]  sa;
        logic signed [SUM_W-1:0]  sb;
    } operands_t;

endpackage

@@ hw/rtl/cdm_cell.sv @@
// One gene column of the chain: row buffer entry, column sum and the
// cross-product sums P[r][index] for rows r >= index. Depends on cdm_pkg.

module cdm_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cdm_pkg::GENE_W-1:0]    index,
    input  logic                          clear,
    input  cdm_pkg::token_t               tok_in,
    output cdm_pkg::token_t               tok_out,
    input  logic                          rd_diag,
    input  logic [cdm_pkg::GENE_W-1:0]    rd_row,
    output logic signed [cdm_pkg::PROD_W-1:0] rd_data,
    output logic signed [cdm_pkg::SUM_W-1:0]  col_sum
);

    cdm_pkg::token_t                            tok_reg;
    logic signed [cdm_pkg::SAMPLE_BITS-1:0]     buf_reg;
    logic signed [cdm_pkg::SUM_W-1:0]           sum_reg;
    logic signed [cdm_pkg::PROD_W-1:0]          cross_reg [cdm_pkg::MAX_GENES];

    logic signed [cdm_pkg::SAMPLE_BITS-1:0]     mult_a;
    logic signed [2*cdm_pkg::SAMPLE_BITS-1:0]   prod;
    logic                                       own_col;
    logic                                       hit;

    // Square on the own column, product with the buffered sample before it
    always_comb
    begin
        own_col = (tok_in.col == index);
        hit     = tok_in.valid && (index <= tok_in.col);
        mult_a  = own_col ? tok_in.value : buf_reg;
        prod    = mult_a * tok_in.value;
    end

    // Hold sums, pass the token on every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
            buf_reg <= '0;
            sum_reg <= '0;
            for (int r = 0; r < cdm_pkg::MAX_GENES; r++)
            begin
                cross_reg[r] <= '0;
            end
        end
        else
        begin
            tok_reg <= tok_in;
            if (clear)
            begin
                sum_reg <= '0;
                for (int r = 0; r < cdm_pkg::MAX_GENES; r++)
                begin
                    cross_reg[r] <= '0;
                end
            end
            else if (hit)
            begin
                cross_reg[tok_in.col] <= cross_reg[tok_in.col] + cdm_pkg::PROD_W'(prod);
                if (own_col)
                begin
                    buf_reg <= tok_in.value;
                    sum_reg <= sum_reg + cdm_pkg::SUM_W'(tok_in.value);
                end
            end
        end
    end

    assign tok_out = tok_reg;
    assign rd_data = cross_reg[rd_diag ? index : rd_row];
    assign col_sum = sum_reg;

endmodule

@@ hw/rtl/cdm_dist.sv @@
// Distance unit: covariance terms, shared 16-bit-chunk squaring and a
// bit-by-bit search for the correlation magnitude. Depends on cdm_pkg.

module cdm_dist (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  cdm_pkg::operands_t            ops,
    output logic                          done,
    output logic [cdm_pkg::DIST_W-1:0]    distance
);

    typedef enum logic [2:0] {D_IDLE, D_SUB, D_SQ, D_PREP, D_SRCH, D_DONE} dstate_t;

    dstate_t                              state_reg;
    logic signed [cdm_pkg::VAR_W-1:0]     np_a_reg, np_b_reg, np_ab_reg;
    logic signed [cdm_pkg::VAR_W-1:0]     ss_a_reg, ss_b_reg, ss_ab_reg;
    logic [cdm_pkg::VAR_W-1:0]            va_reg, vb_reg, cm_reg;
    logic [cdm_pkg::SQ_W-1:0]             v_reg, c2_reg;
    logic [cdm_pkg::RES_W-1:0]            r_reg, qv_reg;
    logic [cdm_pkg::Q_BITS-1:0]           q_reg;
    logic [3:0]                           step_reg;
    logic                                 done_reg;
    logic [cdm_pkg::DIST_W-1:0]           dist_reg;

    logic signed [cdm_pkg::VAR_W-1:0]     n_s;
    logic signed [cdm_pkg::VAR_W-1:0]     va_c, vb_c, cv_c;
    logic [63:0]                          vb_ext, cm_ext;
    logic [15:0]                          vb_chunk, cm_chunk;
    logic [5:0]                           chunk_sh;
    logic [cdm_pkg::SQ_W-1:0]             pv, pc;
    logic [cdm_pkg::RES_W-1:0]            trial;

    always_comb
    begin
        n_s      = cdm_pkg::VAR_W'($signed({1'b0, ops.n}));
        va_c     = np_a_reg - ss_a_reg;
        vb_c     = np_b_reg - ss_b_reg;
        cv_c     = np_ab_reg - ss_ab_reg;
        // One 16-bit digit of each multiplier per cycle
        chunk_sh = {step_reg[1:0], 4'b0000};
        vb_ext   = 64'(vb_reg);
        cm_ext   = 64'(cm_reg);
        vb_chunk = vb_ext[chunk_sh +: 16];
        cm_chunk = cm_ext[chunk_sh +: 16];
        pv       = (cdm_pkg::SQ_W'(va_reg) * cdm_pkg::SQ_W'(vb_chunk)) << chunk_sh;
        pc       = (cdm_pkg::SQ_W'(cm_reg) * cdm_pkg::SQ_W'(cm_chunk)) << chunk_sh;
        // (q + 2^k)^2 - q^2 = 2^(k+1) q + 2^(2k), scaled by the variance product
        trial    = (qv_reg << (step_reg + 4'd1))
                 + (cdm_pkg::RES_W'(v_reg) << {step_reg, 1'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            np_a_reg  <= '0;
            np_b_reg  <= '0;
            np_ab_reg <= '0;
            ss_a_reg  <= '0;
            ss_b_reg  <= '0;
            ss_ab_reg <= '0;
            va_reg    <= '0;
            vb_reg    <= '0;
            cm_reg    <= '0;
            v_reg     <= '0;
            c2_reg    <= '0;
            r_reg     <= '0;
            qv_reg    <= '0;
            q_reg     <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
            dist_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    // Scale cross sums by n, square the column sums and form their product
                    if (start)
                    begin
                        np_a_reg  <= n_s * cdm_pkg::VAR_W'(ops.paa);
                        np_b_reg  <= n_s * cdm_pkg::VAR_W'(ops.pbb);
                        np_ab_reg <= n_s * cdm_pkg::VAR_W'(ops.pab);
                        ss_a_reg  <= cdm_pkg::VAR_W'(ops.sa) * cdm_pkg::VAR_W'(ops.sa);
                        ss_b_reg  <= cdm_pkg::VAR_W'(ops.sb) * cdm_pkg::VAR_W'(ops.sb);
                        ss_ab_reg <= cdm_pkg::VAR_W'(ops.sa) * cdm_pkg::VAR_W'(ops.sb);
                        state_reg <= D_SUB;
                    end
                end
                D_SUB:
                begin
                    // Zero or negative variance: correlation 0
                    if (va_c <= 0 || vb_c <= 0)
                    begin
                        q_reg     <= '0;
                        state_reg <= D_DONE;
                    end
                    else
                    begin
                        va_reg    <= va_c;
                        vb_reg    <= vb_c;
                        cm_reg    <= cv_c[cdm_pkg::VAR_W-1] ? -cv_c : cv_c;
                        v_reg     <= '0;
                        c2_reg    <= '0;
                        step_reg  <= '0;
                        state_reg <= D_SQ;
                    end
                end
                D_SQ:
                begin
                    v_reg    <= v_reg + pv;
                    c2_reg   <= c2_reg + pc;
                    step_reg <= step_reg + 4'd1;
                    if (step_reg[1:0] == 2'd3)
                    begin
                        state_reg <= D_PREP;
                    end
                end
                D_PREP:
                begin
                    r_reg     <= cdm_pkg::RES_W'(c2_reg) << (2 * cdm_pkg::Q_FRAC);
                    qv_reg    <= '0;
                    q_reg     <= '0;
                    step_reg  <= 4'(cdm_pkg::Q_BITS - 1);
                    state_reg <= D_SRCH;
                end
                D_SRCH:
                begin
                    // Keep the bit when the square still fits under the target
                    if (trial <= r_reg)
                    begin
                        r_reg           <= r_reg - trial;
                        qv_reg          <= qv_reg + (cdm_pkg::RES_W'(v_reg) << step_reg);
                        q_reg[step_reg] <= 1'b1;
                    end
                    if (step_reg == 4'd0)
                    begin
                        state_reg <= D_DONE;
                    end
                    else
                    begin
                        step_reg <= step_reg - 4'd1;
                    end
                end
                D_DONE:
                begin
                    done_reg  <= 1'b1;
                    dist_reg  <= q_reg[cdm_pkg::Q_FRAC] ? cdm_pkg::DIST_ZERO
                                                        : cdm_pkg::DIST_ONE - q_reg;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign distance = dist_reg;

endmodule

@@ hw/rtl/correlation_distance_matrix.sv @@
// Top level of the correlation distance matrix: command port, gene cell
// chain and distance unit. Depends on cdm_pkg, cdm_cell and cdm_dist.
//
// Usage:
//   An item (kind, sample_value, gene_a, gene_b) is taken at a clock edge
//   with start high and busy low. A load beat sends the sample down a chain
//   of 16 gene cells, one cell per cycle; each cell whose index is at most
//   the sample's column updates its cross-product sum; busy stays high for
//   the trip of the sample through the chain. A load with the store full
//   only sets the capacity flag and leaves busy low. A clear beat empties
//   all sums. A query beat with a gene index out of range, or with both
//   indices equal, answers on the next cycle. Other queries gather operands
//   from the cells in the T_DIAG and T_CROSS states, then the distance unit
//   runs: products, subtraction, squaring by 16-bit digits, a setup step and
//   16 search steps, and two output registers follow. A zero or negative
//   variance skips squaring and search. The result shows on result for one
//   cycle with done high; it cannot be held off and is lost if not taken.
//   gene_count is written with cfg_we; the user must do so only while the
//   block is idle, as the block does not enforce it. Reset clears all sums
//   and counters and sets gene_count to 16.

module correlation_distance_matrix (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  cdm_pkg::item_t                item,
    output logic                          done,
    output cdm_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [cdm_pkg::GCNT_W-1:0]    cfg_wdata
);

    typedef enum logic [2:0] {T_IDLE, T_LOAD, T_DIAG, T_CROSS, T_WAIT} tstate_t;

    tstate_t                              state_reg;
    logic [cdm_pkg::GCNT_W-1:0]           gcount_reg;
    logic [cdm_pkg::GENE_W-1:0]           pos_reg;
    logic [cdm_pkg::CNT_W-1:0]            count_reg;
    logic                                 ovf_reg;
    cdm_pkg::token_t                      tok_reg;
    logic [cdm_pkg::GENE_W-1:0]           a_reg, b_reg;
    cdm_pkg::operands_t                   ops_reg;
    logic                                 dist_start_reg;
    logic                                 done_reg;
    cdm_pkg::result_t                     result_reg;

    cdm_pkg::token_t                      tok_chain [cdm_pkg::MAX_GENES+1];
    logic signed [cdm_pkg::PROD_W-1:0]    cell_rd   [cdm_pkg::MAX_GENES];
    logic signed [cdm_pkg::SUM_W-1:0]     cell_sum  [cdm_pkg::MAX_GENES];

    logic                                 accept;
    logic                                 clear_cells;
    logic [cdm_pkg::GCNT_W-1:0]           g_use;
    logic [cdm_pkg::GENE_W-1:0]           hi_idx, lo_idx;
    logic                                 rd_diag;
    logic                                 dist_done;
    logic [cdm_pkg::DIST_W-1:0]           dist_value;

    always_comb
    begin
        accept      = start && !busy;
        clear_cells = accept && (item.kind == cdm_pkg::KIND_CLEAR);
        // Gene count of zero acts as one, above the maximum as the maximum
        if (gcount_reg == '0)
        begin
            g_use = cdm_pkg::GCNT_W'(1);
        end
        else if (gcount_reg > cdm_pkg::GCNT_W'(cdm_pkg::MAX_GENES))
        begin
            g_use = cdm_pkg::GCNT_W'(cdm_pkg::MAX_GENES);
        end
        else
        begin
            g_use = gcount_reg;
        end
        hi_idx  = (a_reg > b_reg) ? a_reg : b_reg;
        lo_idx  = (a_reg > b_reg) ? b_reg : a_reg;
        rd_diag = (state_reg == T_DIAG);
    end

    assign tok_chain[0] = tok_reg;

    // Row of gene cells
    for (genvar g = 0; g < cdm_pkg::MAX_GENES; g++)
    begin : g_cell
        cdm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .index   (cdm_pkg::GENE_W'(g)),
            .clear   (clear_cells),
            .tok_in  (tok_chain[g]),
            .tok_out (tok_chain[g+1]),
            .rd_diag (rd_diag),
            .rd_row  (hi_idx),
            .rd_data (cell_rd[g]),
            .col_sum (cell_sum[g])
        );
    end

    cdm_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dist_start_reg),
        .ops      (ops_reg),
        .done     (dist_done),
        .distance (dist_value)
    );

    // Sequence items, track row position and count, gather query operands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_IDLE;
            gcount_reg     <= cdm_pkg::GCNT_W'(cdm_pkg::MAX_GENES);
            pos_reg        <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            tok_reg        <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            ops_reg        <= '0;
            dist_start_reg <= 1'b0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            tok_reg.valid  <= 1'b0;
            dist_start_reg <= 1'b0;
            done_reg       <= 1'b0;
            if (cfg_we)
            begin
                gcount_reg <= cfg_wdata;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        case (item.kind)
                            cdm_pkg::KIND_LOAD:
                            begin
                                if (count_reg >= cdm_pkg::CNT_W'(cdm_pkg::MAX_SAMPLES))
                                begin
                                    ovf_reg <= 1'b1;
                                end
                                else
                                begin
                                    tok_reg.valid <= 1'b1;
                                    tok_reg.value <= item.sample_value;
                                    tok_reg.col   <= pos_reg;
                                    state_reg     <= T_LOAD;
                                    // End the row at the gene count
                                    if ({1'b0, pos_reg} + 5'd1 >= g_use)
                                    begin
                                        pos_reg   <= '0;
                                        count_reg <= count_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        pos_reg <= pos_reg + 1'b1;
                                    end
                                end
                            end
                            cdm_pkg::KIND_CLEAR:
                            begin
                                pos_reg   <= '0;
                                count_reg <= '0;
                                ovf_reg   <= 1'b0;
                            end
                            cdm_pkg::KIND_QUERY:
                            begin
                                if ({1'b0, item.gene_a} >= g_use || {1'b0, item.gene_b} >= g_use)
                                begin
                                    result_reg.distance <= cdm_pkg::DIST_ONE;
                                    result_reg.status   <= cdm_pkg::STATUS_RANGE;
                                    result_reg.capacity_exceeded <= ovf_reg;
                                    done_reg <= 1'b1;
                                end
                                else if (item.gene_a == item.gene_b)
                                begin
                                    result_reg.distance <= cdm_pkg::DIST_ZERO;
                                    result_reg.status   <= cdm_pkg::STATUS_OK;
                                    result_reg.capacity_exceeded <= ovf_reg;
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    a_reg     <= item.gene_a;
                                    b_reg     <= item.gene_b;
                                    state_reg <= T_DIAG;
                                end
                            end
                            default:
                            begin
                                state_reg <= T_IDLE;
                            end
                        endcase
                    end
                end
                T_LOAD:
                begin
                    // Release once the sample has left the last cell
                    if (tok_chain[cdm_pkg::MAX_GENES].valid)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                T_DIAG:
                begin
                    ops_reg.n   <= count_reg;
                    ops_reg.paa <= cell_rd[a_reg];
                    ops_reg.pbb <= cell_rd[b_reg];
                    ops_reg.sa  <= cell_sum[a_reg];
                    ops_reg.sb  <= cell_sum[b_reg];
                    state_reg   <= T_CROSS;
                end
                T_CROSS:
                begin
                    ops_reg.pab    <= cell_rd[lo_idx];
                    dist_start_reg <= 1'b1;
                    state_reg      <= T_WAIT;
                end
                T_WAIT:
                begin
                    if (dist_done)
                    begin
                        result_reg.distance <= dist_value;
                        result_reg.status   <= cdm_pkg::STATUS_OK;
                        result_reg.capacity_exceeded <= ovf_reg;
                        done_reg  <= 1'b1;
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != T_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for correlation_distance_matrix: drives load, clear
// and query beats, predicts every distance result and checks it on done.
// Depends on cdm_pkg and the correlation_distance_matrix RTL.

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 40;

    // value styles for generated rows
    localparam int STYLE_FULL     = 0;
    localparam int STYLE_NARROW   = 1;
    localparam int STYLE_LINKED   = 2;
    localparam int STYLE_EXTREME  = 3;
    localparam int STYLE_CONSTANT = 4;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    cdm_pkg::item_t               item;
    logic                         done;
    cdm_pkg::result_t             result;
    logic                         cfg_we;
    logic [cdm_pkg::GCNT_W-1:0]   cfg_wdata;

    correlation_distance_matrix DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Mirror of the block state
    longint unsigned   row_mirror [cdm_pkg::MAX_GENES];
    longint unsigned   col_sum [cdm_pkg::MAX_GENES];
    longint unsigned   pair_sum [cdm_pkg::MAX_GENES*cdm_pkg::MAX_GENES];
    int unsigned       full_rows;
    int unsigned       row_pos;
    bit                cap_flag;
    logic [cdm_pkg::GCNT_W-1:0] gene_reg;

    cdm_pkg::item_t   beats_pending [$];
    cdm_pkg::result_t distances_due [$];
    int      error_count;
    int      wait_left;
    int      next_gap;
    bit      calm;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned genes_active();
        if (gene_reg == 0) return 1;
        if (gene_reg > cdm_pkg::MAX_GENES) return cdm_pkg::MAX_GENES;
        return gene_reg;
    endfunction

    function automatic void clear_mirror();
        foreach (col_sum[i]) col_sum[i] = 0;
        foreach (pair_sum[i]) pair_sum[i] = 0;
        full_rows = 0;
        row_pos   = 0;
        cap_flag  = 1'b0;
    endfunction

    // Accumulate one sample into sums and cross products
    function automatic void accumulate(logic signed [cdm_pkg::SAMPLE_BITS-1:0] s);
        longint unsigned v;
        int unsigned c;
        c = row_pos % cdm_pkg::MAX_GENES;
        if (full_rows >= cdm_pkg::MAX_SAMPLES)
        begin
            cap_flag = 1'b1;
            return;
        end
        v = {{(64-cdm_pkg::SAMPLE_BITS){s[cdm_pkg::SAMPLE_BITS-1]}}, s};
        row_mirror[c] = v;
        col_sum[c] += v;
        for (int j = 0; j < c; j++)
            pair_sum[c*cdm_pkg::MAX_GENES + j] += v * row_mirror[j];
        pair_sum[c*cdm_pkg::MAX_GENES + c] += v * v;
        if (c + 1 >= genes_active())
        begin
            row_pos = 0;
            full_rows++;
        end
        else
            row_pos = c + 1;
    endfunction

    // Distance 1-|corr| in Q1.15 by search for the largest fitting |corr|
    function automatic logic [cdm_pkg::DIST_W-1:0] corr_distance(int unsigned a,
                                                                 int unsigned b);
        longint unsigned n, va, vb, cv, cmag;
        logic [127:0] vprod, target, trial;
        int unsigned hi, lo, qlo, qhi, mid;
        if (a == b) return cdm_pkg::DIST_ZERO;
        n  = full_rows;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        va = n * pair_sum[a*cdm_pkg::MAX_GENES + a] - col_sum[a] * col_sum[a];
        vb = n * pair_sum[b*cdm_pkg::MAX_GENES + b] - col_sum[b] * col_sum[b];
        if (va == 0 || va[63] || vb == 0 || vb[63]) return cdm_pkg::DIST_ONE;
        cv    = n * pair_sum[hi*cdm_pkg::MAX_GENES + lo] - col_sum[a] * col_sum[b];
        cmag  = cv[63] ? -cv : cv;
        vprod = 128'(va) * 128'(vb);
        target = (128'(cmag) * 128'(cmag)) << 30;
        qlo = 0;
        qhi = 32768;
        while (qlo < qhi)
        begin
            mid   = (qlo + qhi + 1) >> 1;
            trial = vprod * 128'(64'(mid) * 64'(mid));
            if (trial <= target) qlo = mid;
            else qhi = mid - 1;
        end
        return cdm_pkg::DIST_W'(32768 - qlo);
    endfunction

    // Update the mirror for one accepted beat; queue the result it causes
    function automatic void apply_beat(cdm_pkg::item_t it);
        cdm_pkg::result_t r;
        case (it.kind)
            cdm_pkg::KIND_LOAD: accumulate(it.sample_value);
            cdm_pkg::KIND_CLEAR: clear_mirror();
            cdm_pkg::KIND_QUERY:
            begin
                if (it.gene_a >= genes_active() || it.gene_b >= genes_active())
                begin
                    r.distance = cdm_pkg::DIST_ONE;
                    r.status   = cdm_pkg::STATUS_RANGE;
                end
                else
                begin
                    r.distance = corr_distance(it.gene_a, it.gene_b);
                    r.status   = cdm_pkg::STATUS_OK;
                end
                r.capacity_exceeded = cap_flag;
                distances_due = {distances_due, r};
            end
            default: ;
        endcase
    endfunction

    function automatic int draw_gap();
        if ($urandom_range(0, 49) == 0) calm = ~calm;
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    // Driver: present beats, hold until accepted, idle a random gap (possibly none) between them
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            wait_left <= 0;
        end
        else if (start && !busy)
        begin
            apply_beat(item);
            if (next_gap == 0 && beats_pending.size() > 0)
            begin
                item     <= beats_pending.pop_front();
                next_gap = draw_gap();
            end
            else
            begin
                start     <= 1'b0;
                wait_left <= next_gap;
            end
        end
        else if (!start)
        begin
            if (wait_left > 0)
                wait_left <= wait_left - 1;
            else if (beats_pending.size() > 0)
            begin
                start    <= 1'b1;
                item     <= beats_pending.pop_front();
                next_gap = draw_gap();
            end
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Monitor: check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        cdm_pkg::result_t want;
        if (rst_n && done)
        begin
            if (distances_due.size() == 0)
                report_mismatch("unexpected result, distance", result.distance, -1);
            else
            begin
                want = distances_due.pop_front();
                if (result.distance !== want.distance)
                    report_mismatch("distance", result.distance, want.distance);
                if (result.status !== want.status)
                    report_mismatch("status", result.status, want.status);
                if (result.capacity_exceeded !== want.capacity_exceeded)
                    report_mismatch("capacity_exceeded", result.capacity_exceeded,
                                    want.capacity_exceeded);
            end
        end
    end

    function automatic void add_beat(logic [1:0] k, int v, int a, int b);
        cdm_pkg::item_t it;
        it.kind         = k;
        it.sample_value = cdm_pkg::SAMPLE_BITS'(v);
        it.gene_a       = cdm_pkg::GENE_W'(a);
        it.gene_b       = cdm_pkg::GENE_W'(b);
        beats_pending = {beats_pending, it};
    endfunction

    function automatic void add_load(int v);
        add_beat(cdm_pkg::KIND_LOAD, v, $urandom_range(0, 15), $urandom_range(0, 15));
    endfunction

    function automatic void add_query(int a, int b);
        add_beat(cdm_pkg::KIND_QUERY, $urandom, a, b);
    endfunction

    // Wait until the block has drained, then let trailing work finish
    task automatic settle();
        while (beats_pending.size() > 0 || start || distances_due.size() > 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_genes(int v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= cdm_pkg::GCNT_W'(v);
        gene_reg  = cdm_pkg::GCNT_W'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int sample_for(int style, int col, int base);
        int pick;
        case (style)
            STYLE_NARROW: return $urandom_range(0, 6) - 3;
            STYLE_LINKED:
                return ((col % 2) ? -base : base) * (col + 1) / 4 + $urandom_range(0, 4) - 2;
            STYLE_EXTREME:
            begin
                pick = $urandom_range(0, 3);
                return (pick == 0) ? -32768 : (pick == 1) ? 32767 : (pick == 2) ? 0 : -1;
            end
            STYLE_CONSTANT: return col * 100 - 700;
            default: return $urandom;
        endcase
    endfunction

    // Mostly loads with queries mixed in; rare clears and unused kinds
    function automatic void fill_random(int count, int style, int gc);
        int roll, col, base, a, b;
        col  = 0;
        base = $urandom_range(0, 4000) - 2000;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 68)
            begin
                add_load(sample_for(style, col, base));
                col++;
                if (col >= gc)
                begin
                    col  = 0;
                    base = $urandom_range(0, 4000) - 2000;
                end
            end
            else if (roll < 96)
            begin
                a = ($urandom_range(0, 9) < 8) ? $urandom_range(0, gc - 1) : $urandom_range(0, 15);
                b = ($urandom_range(0, 9) < 8) ? $urandom_range(0, gc - 1) : $urandom_range(0, 15);
                add_query(a, b);
            end
            else if (roll < 97)
            begin
                add_beat(cdm_pkg::KIND_CLEAR, $urandom, $urandom_range(0, 15),
                         $urandom_range(0, 15));
                col = 0;
            end
            else
                add_beat(KIND_UNUSED, $urandom, $urandom_range(0, 15), $urandom_range(0, 15));
        end
    endfunction

    initial
    begin
        #5000000;
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        int gcs [9]    = '{2, 3, 8, 0, 31, 16, 5, 12, 4};
        int styles [9] = '{STYLE_LINKED, STYLE_FULL, STYLE_NARROW, STYLE_CONSTANT, STYLE_FULL,
                           STYLE_EXTREME, STYLE_LINKED, STYLE_NARROW, STYLE_CONSTANT};
        int eff;
        error_count = 0;
        calm        = 1'b0;
        next_gap    = 0;
        start       = 1'b0;
        item        = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        gene_reg    = cdm_pkg::GCNT_W'(cdm_pkg::MAX_GENES);
        clear_mirror();
        foreach (row_mirror[i]) row_mirror[i] = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty store, same gene, full row of extremes, unused kind, clear
        add_query(0, 1);
        add_query(7, 7);
        add_load(-32768);
        add_load(32767);
        add_load(0);
        add_load(-1);
        for (int i = 4; i < 16; i++) add_load((i % 2) ? 32767 : -32768);
        add_query(0, 1);
        add_query(15, 0);
        add_beat(KIND_UNUSED, 0, 0, 1);
        add_beat(cdm_pkg::KIND_CLEAR, 0, 0, 0);
        add_query(0, 1);

        // Out-of-range indices and a gene count change in mid-row
        write_genes(4);
        fill_random(40, STYLE_LINKED, 4);
        add_query(15, 0);
        add_query(0, 4);
        add_load(123);
        write_genes(2);
        add_load(-77);
        add_query(0, 1);

        // Fill the store to capacity, then overflow it
        write_genes(1);
        add_beat(cdm_pkg::KIND_CLEAR, 0, 0, 0);
        for (int i = 0; i < cdm_pkg::MAX_SAMPLES + 3; i++) add_load($urandom);
        add_query(0, 0);
        add_query(0, 1);
        write_genes(2);
        add_load(5);
        add_query(0, 1);
        add_beat(cdm_pkg::KIND_CLEAR, 0, 0, 0);
        add_query(0, 1);

        // Random phases across gene count settings
        foreach (gcs[p])
        begin
            write_genes(gcs[p]);
            eff = (gcs[p] == 0) ? 1 : (gcs[p] > cdm_pkg::MAX_GENES) ? cdm_pkg::MAX_GENES
                                                                    : gcs[p];
            fill_random(80, styles[p], eff);
        end

        settle();
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
